FILE: hdl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int MS_TICKS = 1000;
  localparam int DAC_BITS = 14;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 14;
  localparam int KIND_W  = 3;
  localparam int COUNT_W = 16;
  localparam int WAIT_W  = 18;
  localparam int MS_W    = $clog2(MS_TICKS + 1);
  localparam int SUM_W   = BYTE_W + MS_W + 2;

  localparam logic [COUNT_W-1:0] HEIGHT_MAX = 16'd15084;
  localparam logic [COUNT_W-1:0] DAC_MASK   = COUNT_W'((32'd1 << DAC_BITS) - 32'd1);
  localparam logic [SUM_W-1:0]   WAIT_MAX   = SUM_W'((32'd1 << WAIT_W) - 32'd1);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [BYTE_W-1:0] CH_G_UP  = 8'h47;
  localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CH_H_UP  = 8'h48;
  localparam logic [BYTE_W-1:0] CH_L_UP  = 8'h4C;
  localparam logic [BYTE_W-1:0] CH_M_UP  = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_P_UP  = 8'h50;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_G     = 8'h67;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_X     = 8'h78;
  localparam logic [BYTE_W-1:0] CH_Y     = 8'h79;
  localparam logic [BYTE_W-1:0] CH_Z     = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [BYTE_W-1:0] CH_Y_UP  = 8'h59;
  localparam logic [BYTE_W-1:0] CH_Z_UP  = 8'h5A;

  typedef enum logic [KIND_W-1:0] {
    KIND_DAC    = 3'd0,
    KIND_COARSE = 3'd1,
    KIND_FINE   = 3'd2,
    KIND_PULSE  = 3'd3,
    KIND_REPLY  = 3'd4,
    KIND_STOP   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               trigger_enabled;
    logic               led_on;
  } res_t;

  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qport_t;

endpackage

FILE: hdl/pcc_front.sv
`timescale 1ns / 1ps

module pcc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  func,
  input  logic [7:0]            rx_byte,
  output pcc_pkg::qport_t       push
);
  import pcc_pkg::*;

  typedef enum logic [10:0] {
    PS_HUNT   = 11'b000_0000_0001,
    PS_AT     = 11'b000_0000_0010,
    PS_CMD    = 11'b000_0000_0100,
    PS_CNT_LO = 11'b000_0000_1000,
    PS_CNT_HI = 11'b000_0001_0000,
    PS_HGT_HI = 11'b000_0010_0000,
    PS_HGT_LO = 11'b000_0100_0000,
    PS_COARSE = 11'b000_1000_0000,
    PS_FINE   = 11'b001_0000_0000,
    PS_PER_MS = 11'b010_0000_0000,
    PS_PER_US = 11'b100_0000_0000
  } parse_t;

  typedef enum logic [2:0] {
    RM_IDLE    = 3'b001,
    RM_COUNTED = 3'b010,
    RM_CONT    = 3'b100
  } run_t;

  parse_t              parse_state, parse_state_next;
  run_t                run_mode, run_mode_next;
  logic [BYTE_W-1:0]   count_high, count_high_next;
  logic [BYTE_W-1:0]   count_low, count_low_next;
  logic [BYTE_W-1:0]   height_high, height_high_next;
  logic [BYTE_W-1:0]   height_low, height_low_next;
  logic [BYTE_W-1:0]   period_ms, period_ms_next;
  logic [BYTE_W-1:0]   period_us, period_us_next;
  logic [COUNT_W-1:0]  pulses_left, pulses_left_next;
  logic [WAIT_W-1:0]   wait_ticks, wait_ticks_next;
  logic                trigger_on, trigger_on_next;
  logic                lamp_on, lamp_on_next;

  logic [SUM_W-1:0]    wait_sum;
  logic [WAIT_W-1:0]   wait_load;
  logic [COUNT_W-1:0]  count_prod;
  logic [COUNT_W-1:0]  height_word;
  logic [COUNT_W-1:0]  dac_word;

  logic                stop_fire;
  logic                cmd_fire;
  res_t                stop_res;
  res_t                cmd_res;
  logic                running;
  logic                stop_now;

  assign wait_sum  = SUM_W'(period_ms) * SUM_W'(MS_TICKS) + SUM_W'({period_us, 2'b00});
  assign wait_load = (wait_sum > WAIT_MAX) ? WAIT_MAX[WAIT_W-1:0] : wait_sum[WAIT_W-1:0];
  assign count_prod  = COUNT_W'(count_high) * COUNT_W'(count_low);
  assign height_word = (({height_high, height_low}) > HEIGHT_MAX) ? HEIGHT_MAX
                                                                  : {height_high, height_low};
  assign dac_word    = height_word & DAC_MASK;
  assign running     = (run_mode == RM_COUNTED) || (run_mode == RM_CONT);

  always_comb begin
    parse_state_next = parse_state;
    run_mode_next    = run_mode;
    count_high_next  = count_high;
    count_low_next   = count_low;
    height_high_next = height_high;
    height_low_next  = height_low;
    period_ms_next   = period_ms;
    period_us_next   = period_us;
    pulses_left_next = pulses_left;
    wait_ticks_next  = wait_ticks;
    trigger_on_next  = trigger_on;
    lamp_on_next     = lamp_on;
    stop_fire        = 1'b0;
    cmd_fire         = 1'b0;
    stop_res         = '0;
    cmd_res          = '0;
    stop_now         = 1'b0;

    if (func) begin
      // tick
      if (running) begin
        if (wait_ticks > WAIT_W'(1)) begin
          wait_ticks_next = wait_ticks - WAIT_W'(1);
        end else begin
          wait_ticks_next = '0;
          if (run_mode == RM_COUNTED) begin
            if (pulses_left != '0) begin
              pulses_left_next = pulses_left - COUNT_W'(1);
            end
            if (pulses_left_next == '0) begin
              stop_now = 1'b1;
            end
          end
          if (stop_now) begin
            run_mode_next    = RM_IDLE;
            trigger_on_next  = 1'b0;
            pulses_left_next = '0;
            stop_fire        = 1'b1;
            stop_res         = '{kind: KIND_STOP, value: '0, trigger_enabled: 1'b0,
                                 led_on: lamp_on};
          end else begin
            wait_ticks_next = wait_load;
            cmd_fire        = 1'b1;
            cmd_res         = '{kind: KIND_PULSE, value: '0, trigger_enabled: trigger_on,
                                led_on: lamp_on};
          end
        end
      end
    end else begin
      // received byte: stop any run, then parse
      if (running) begin
        if (run_mode == RM_CONT) begin
          lamp_on_next = 1'b0;
        end
        trigger_on_next  = 1'b0;
        pulses_left_next = '0;
        wait_ticks_next  = '0;
        stop_fire        = 1'b1;
        stop_res         = '{kind: KIND_STOP, value: '0, trigger_enabled: 1'b0,
                             led_on: lamp_on_next};
      end
      run_mode_next = RM_IDLE;

      unique case (parse_state)
        PS_AT: begin
          parse_state_next = (rx_byte == CH_AT) ? PS_CMD : PS_HUNT;
        end
        PS_CMD: begin
          parse_state_next = PS_HUNT;
          unique case (rx_byte)
            CH_G_UP: parse_state_next = PS_CNT_LO;
            CH_H_UP: parse_state_next = PS_CNT_HI;
            CH_L_UP: parse_state_next = PS_HGT_HI;
            CH_M_UP: parse_state_next = PS_HGT_LO;
            CH_D:    parse_state_next = PS_COARSE;
            CH_E:    parse_state_next = PS_FINE;
            CH_U:    parse_state_next = PS_PER_MS;
            CH_P_UP: begin
              cmd_fire = 1'b1;
              cmd_res  = '{kind: KIND_DAC, value: dac_word[VALUE_W-1:0],
                           trigger_enabled: trigger_on_next, led_on: lamp_on_next};
            end
            CH_X: begin
              cmd_fire = 1'b1;
              cmd_res  = '{kind: KIND_REPLY, value: VALUE_W'(CH_X_UP),
                           trigger_enabled: trigger_on_next, led_on: lamp_on_next};
            end
            CH_Y: begin
              cmd_fire = 1'b1;
              cmd_res  = '{kind: KIND_REPLY, value: VALUE_W'(CH_Y_UP),
                           trigger_enabled: trigger_on_next, led_on: lamp_on_next};
            end
            CH_Z: begin
              cmd_fire = 1'b1;
              cmd_res  = '{kind: KIND_REPLY, value: VALUE_W'(CH_Z_UP),
                           trigger_enabled: trigger_on_next, led_on: lamp_on_next};
            end
            CH_G: begin
              pulses_left_next = (count_prod == '0) ? COUNT_W'(1) : count_prod;
              run_mode_next    = RM_COUNTED;
              trigger_on_next  = 1'b1;
              lamp_on_next     = 1'b1;
              wait_ticks_next  = wait_load;
              cmd_fire         = 1'b1;
              cmd_res          = '{kind: KIND_PULSE, value: '0, trigger_enabled: 1'b1,
                                   led_on: 1'b1};
            end
            CH_A: begin
              pulses_left_next = '0;
              run_mode_next    = RM_CONT;
              trigger_on_next  = 1'b1;
              lamp_on_next     = 1'b1;
              wait_ticks_next  = wait_load;
              cmd_fire         = 1'b1;
              cmd_res          = '{kind: KIND_PULSE, value: '0, trigger_enabled: 1'b1,
                                   led_on: 1'b1};
            end
            default: parse_state_next = PS_HUNT;
          endcase
        end
        PS_CNT_LO: begin
          count_low_next   = rx_byte;
          parse_state_next = PS_HUNT;
        end
        PS_CNT_HI: begin
          count_high_next  = rx_byte;
          parse_state_next = PS_HUNT;
        end
        PS_HGT_HI: begin
          height_high_next = rx_byte;
          parse_state_next = PS_HUNT;
        end
        PS_HGT_LO: begin
          height_low_next  = rx_byte;
          parse_state_next = PS_HUNT;
        end
        PS_COARSE: begin
          parse_state_next = PS_HUNT;
          cmd_fire         = 1'b1;
          cmd_res          = '{kind: KIND_COARSE, value: VALUE_W'(rx_byte),
                               trigger_enabled: trigger_on_next, led_on: lamp_on_next};
        end
        PS_FINE: begin
          parse_state_next = PS_HUNT;
          cmd_fire         = 1'b1;
          cmd_res          = '{kind: KIND_FINE, value: VALUE_W'(rx_byte),
                               trigger_enabled: trigger_on_next, led_on: lamp_on_next};
        end
        PS_PER_MS: begin
          period_ms_next   = rx_byte;
          parse_state_next = PS_PER_US;
        end
        PS_PER_US: begin
          period_us_next   = rx_byte;
          parse_state_next = PS_HUNT;
        end
        default: begin
          parse_state_next = (rx_byte == CH_G_UP) ? PS_AT : PS_HUNT;
        end
      endcase
    end
  end

  // pack up to two results into one queue entry
  always_comb begin
    push.valid        = accept && (stop_fire || cmd_fire);
    push.entry.two    = stop_fire && cmd_fire;
    push.entry.first  = stop_fire ? stop_res : cmd_res;
    push.entry.second = cmd_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= PS_HUNT;
      run_mode    <= RM_IDLE;
      count_high  <= '0;
      count_low   <= '0;
      height_high <= '0;
      height_low  <= '0;
      period_ms   <= '0;
      period_us   <= '0;
      pulses_left <= '0;
      wait_ticks  <= '0;
      trigger_on  <= 1'b0;
      lamp_on     <= 1'b0;
    end else if (accept) begin
      parse_state <= parse_state_next;
      run_mode    <= run_mode_next;
      count_high  <= count_high_next;
      count_low   <= count_low_next;
      height_high <= height_high_next;
      height_low  <= height_low_next;
      period_ms   <= period_ms_next;
      period_us   <= period_us_next;
      pulses_left <= pulses_left_next;
      wait_ticks  <= wait_ticks_next;
      trigger_on  <= trigger_on_next;
      lamp_on     <= lamp_on_next;
    end
  end

endmodule

FILE: hdl/pcc_queue.sv
`timescale 1ns / 1ps

module pcc_queue (
  input  logic             clk,
  input  logic             rst,
  input  pcc_pkg::qport_t  push,
  output logic             space,
  output pcc_pkg::qport_t  head,
  input  logic             pop
);
  import pcc_pkg::*;

  entry_t          slots [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    fill;
  logic            do_pop;

  assign space      = (fill != (QAW + 1)'(QDEPTH));
  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push.valid && !do_pop) begin
        fill <= fill + (QAW + 1)'(1);
      end else if (!push.valid && do_pop) begin
        fill <= fill - (QAW + 1)'(1);
      end
    end
  end

endmodule

FILE: hdl/pcc_back.sv
`timescale 1ns / 1ps

module pcc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  pcc_pkg::qport_t             head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pcc_pkg::KIND_W-1:0]  kind,
  output logic [pcc_pkg::VALUE_W-1:0] value,
  output logic                        trigger_enabled,
  output logic                        led_on,
  output logic                        last
);
  import pcc_pkg::*;

  logic sel;
  res_t cur;

  assign cur             = sel ? head.entry.second : head.entry.first;
  assign out_valid       = head.valid;
  assign kind            = cur.kind;
  assign value           = cur.value;
  assign trigger_enabled = cur.trigger_enabled;
  assign led_on          = cur.led_on;
  assign last            = sel || !head.entry.two;
  assign pop             = out_valid && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (out_valid && out_ready) begin
      sel <= !last;
    end
  end

endmodule

FILE: hdl/pulser_command_controller.sv
`timescale 1ns / 1ps
// channel  | signals                                  | direction
// input    | in_valid, in_ready, func, rx_byte        | in
// output   | out_valid, out_ready, kind, value,       | out
//          | trigger_enabled, led_on, last            |
// one item is accepted per cycle while the 4-entry result queue has room
// results leave one per cycle while out_ready is high; a byte that stops a run and yields its own result gives two
// a result appears on the output the cycle after its item enters an empty queue
// rst synchronously clears parser, run state and queue
// a stalled output fills the queue and then drops in_ready

module pulser_command_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        func,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pcc_pkg::KIND_W-1:0]  kind,
  output logic [pcc_pkg::VALUE_W-1:0] value,
  output logic                        trigger_enabled,
  output logic                        led_on,
  output logic                        last
);
  import pcc_pkg::*;

  qport_t push;
  qport_t head;
  logic   space;
  logic   pop;
  logic   accept;

  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  pcc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .func    (func),
    .rx_byte (rx_byte),
    .push    (push)
  );

  pcc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .space (space),
    .head  (head),
    .pop   (pop)
  );

  pcc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .value           (value),
    .trigger_enabled (trigger_enabled),
    .led_on          (led_on),
    .last            (last)
  );

endmodule

FILE: hdl/pcc_checker.sv
`timescale 1ns / 1ps

module pcc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pcc_pkg::KIND_W-1:0]  kind,
  input logic [pcc_pkg::VALUE_W-1:0] value,
  input logic                        trigger_enabled,
  input logic                        led_on,
  input logic                        last
);
  import pcc_pkg::*;

  // a pending result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value))
    else $error("result dropped or changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_STOP)
    else $error("undefined result kind");

  a_pulse_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PULSE |-> trigger_enabled && led_on && value == '0)
    else $error("pulse without armed trigger");

  a_stop_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STOP |-> !trigger_enabled && value == '0)
    else $error("stop leaves trigger armed");

  // a non-final result is always followed by a final one
  a_pair_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last)
    else $error("second result missing");

endmodule

bind pulser_command_controller pcc_checker u_checker (.*);
